// File: design/assert_macros.svh
// Assertion macros shared by the bitmap allocator modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property checked at every clock edge outside reset.
`define FBA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Consequent checked in the cycle after the antecedent.
`define FBA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define FBA_ASSERT(lbl, clk, rst_n, prop, msg)
`define FBA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: design/fba_pkg.sv
// Shared types, codes and field widths of the bitmap allocator.
package fba_pkg;

    localparam int IDX_W     = 16;
    localparam int FDZ_W     = 15;
    localparam int ZCNT_W    = 16;
    localparam int ICNT_W    = 15;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int ACT_W     = 3;
    localparam int STAT_W    = 2;

    typedef enum logic [ACT_W-1:0] {
        ACT_QUERY = 3'd0,
        ACT_SET   = 3'd1,
        ACT_CLEAR = 3'd2,
        ACT_ALLOC = 3'd3,
        ACT_COUNT = 3'd4
    } t_action;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FIRST_ZONE  = 2'd0,
        CFG_ZONE_COUNT  = 2'd1,
        CFG_INODE_COUNT = 2'd2
    } t_cfg_reg;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr;
        logic load;
        logic prep;
        logic upd;
        logic scan;
        logic post;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;
        logic is_scan;
        logic is_alloc;
        logic hit;
        logic last;
        logic out_busy;
    } t_dp_stat;

endpackage

// File: design/fba_ifs.sv
// Request and response channel interfaces of the bitmap allocator.
interface fba_req_if;
    import fba_pkg::*;
    logic              valid;
    logic              ready;
    logic [ACT_W-1:0]  action;
    logic              map_select;
    logic [IDX_W-1:0]  item_index;

    modport source (output valid, action, map_select, item_index, input ready);
    modport sink   (input valid, action, map_select, item_index, output ready);
endinterface

interface fba_rsp_if;
    import fba_pkg::*;
    logic              valid;
    logic              ready;
    logic              in_use;
    logic [IDX_W-1:0]  granted_index;
    logic [IDX_W-1:0]  free_total;
    logic [STAT_W-1:0] status;

    modport source (output valid, in_use, granted_index, free_total, status, input ready);
    modport sink   (input valid, in_use, granted_index, free_total, status, output ready);
endinterface

// File: design/fs_bitmap_allocator.sv
// Top level of the inode and data zone bitmap allocator.
//
//   channel   dir  handshake          payload
//   i_req     in   valid/ready        action, map_select, item_index
//   o_rsp     out  valid/ready        in_use, granted_index, free_total, status
//   cfg       in   i_cfg_we           i_cfg_idx, i_cfg_data
//
// Query, set and clear pass through the access, update and finish states before
// the result is posted. Allocate and count read one bitmap word per cycle from the
// selected memory, at most MAP_WORDS words (1024 at default parameters); allocate
// stops at the first free bit. After reset both bitmaps are cleared in parallel, one
// word a cycle over all MAP_WORDS words (1024 by default); ready stays low meanwhile.
// A result waits in the output register while the next item is taken; an item
// finished while that register is still full holds until it drains.
module fs_bitmap_allocator #(
    parameter int MAP_BITS  = 32768,
    parameter int WORD_BITS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    fba_req_if.sink                       i_req,
    fba_rsp_if.source                     o_rsp,
    input  logic                          i_cfg_we,
    input  logic [fba_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [fba_pkg::CFG_W-1:0]     i_cfg_data
);
    import fba_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;
    logic     w_in_ready;

    fba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd),
        .i_stat     (w_stat)
    );

    fba_datapath #(
        .MAP_BITS  (MAP_BITS),
        .WORD_BITS (WORD_BITS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_action        (i_req.action),
        .i_map_select    (i_req.map_select),
        .i_item_index    (i_req.item_index),
        .i_out_ready     (o_rsp.ready),
        .o_out_valid     (o_rsp.valid),
        .o_in_use        (o_rsp.in_use),
        .o_granted_index (o_rsp.granted_index),
        .o_free_total    (o_rsp.free_total),
        .o_status        (o_rsp.status)
    );

    assign i_req.ready = w_in_ready;

endmodule

// File: design/fba_ctrl.sv
// Controller state machine: sequences clearing, single accesses and scans.
`include "assert_macros.svh"
module fba_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output fba_pkg::t_dp_cmd  o_cmd,
    input  fba_pkg::t_dp_stat i_stat
);
    import fba_pkg::*;

    typedef enum logic [5:0] {
        S_CLEAR  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_ACCESS = 6'b000100,
        S_UPDATE = 6'b001000,
        S_SCAN   = 6'b010000,
        S_FINISH = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_ACCESS;
                end
            end
            S_ACCESS: begin
                o_cmd.prep = 1'b1;
                n_state    = i_stat.is_scan ? S_SCAN : S_UPDATE;
            end
            S_UPDATE: begin
                o_cmd.upd = 1'b1;
                n_state   = S_FINISH;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                // stop on the first free bit of an allocation, or after the last word
                if ((i_stat.is_alloc && i_stat.hit) || i_stat.last) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                // hold the result until the output register is free
                if (!i_stat.out_busy) begin
                    o_cmd.post = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    `FBA_ASSERT_NEXT(a_scan_ends, i_clk, i_rst_n, r_state == S_SCAN && i_stat.last, r_state == S_FINISH, "scan ran past the last word")
    `FBA_ASSERT_NEXT(a_post_frees, i_clk, i_rst_n, o_cmd.post, o_in_ready, "not ready after posting a result")

endmodule

// File: design/fba_datapath.sv
// Datapath: configuration, bitmap memories, word scan logic and result register.
`include "assert_macros.svh"
module fba_datapath #(
    parameter int MAP_BITS  = 32768,
    parameter int WORD_BITS = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  fba_pkg::t_dp_cmd               i_cmd,
    output fba_pkg::t_dp_stat              o_stat,
    input  logic                           i_cfg_we,
    input  logic [fba_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [fba_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic [fba_pkg::ACT_W-1:0]      i_action,
    input  logic                           i_map_select,
    input  logic [fba_pkg::IDX_W-1:0]      i_item_index,
    input  logic                           i_out_ready,
    output logic                           o_out_valid,
    output logic                           o_in_use,
    output logic [fba_pkg::IDX_W-1:0]      o_granted_index,
    output logic [fba_pkg::IDX_W-1:0]      o_free_total,
    output logic [fba_pkg::STAT_W-1:0]     o_status
);
    import fba_pkg::*;

    // WORD_BITS is a power of two; bit n lives in word n >> OW at offset n & mask
    localparam int MAP_WORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int OW        = $clog2(WORD_BITS);
    localparam int SW        = AW + 1;
    localparam int BW        = IDX_W + 1;
    localparam int CW        = OW + 1;
    localparam logic [BW-1:0] MAP_LIMIT  = BW'(MAP_BITS);
    localparam logic [BW:0]   WORD_SPAN  = (BW+1)'(WORD_BITS);
    localparam logic [AW-1:0] LAST_WORD  = AW'(MAP_WORDS - 1);
    localparam logic [SW-1:0] WORD_TOTAL = SW'(MAP_WORDS);

    // configuration
    logic [FDZ_W-1:0]  r_fdz;
    logic [ZCNT_W-1:0] r_zc;
    logic [ICNT_W-1:0] r_ic;

    // current item
    logic [ACT_W-1:0]  r_action;
    logic              r_sel;
    logic [IDX_W-1:0]  r_idx;

    // scan control
    logic [AW-1:0]     r_clr;
    logic [SW-1:0]     r_sa;
    logic [AW-1:0]     r_pa;
    logic              r_pv;
    logic [BW-1:0]     r_upper;
    logic              r_lo_one;

    // result and output registers
    logic              r_res_in_use;
    logic [IDX_W-1:0]  r_res_granted;
    logic [IDX_W-1:0]  r_acc;
    logic [STAT_W-1:0] r_res_status;
    logic              r_out_valid;
    logic              r_out_in_use;
    logic [IDX_W-1:0]  r_out_granted;
    logic [IDX_W-1:0]  r_out_free;
    logic [STAT_W-1:0] r_out_status;

    // memories
    logic [WORD_BITS-1:0] r_imem [MAP_WORDS];
    logic [WORD_BITS-1:0] r_zmem [MAP_WORDS];
    logic [WORD_BITS-1:0] r_ird;
    logic [WORD_BITS-1:0] r_zrd;

    logic                 w_zone_map;
    logic                 w_is_scan;
    logic                 w_is_alloc;
    logic                 w_reserved;
    logic [IDX_W-1:0]     w_bit;
    logic                 w_oor;
    logic [AW-1:0]        w_waddr;
    logic [OW-1:0]        w_off;
    logic [BW-1:0]        w_zlim;
    logic [BW-1:0]        w_ilim;
    logic [BW-1:0]        w_lim;
    logic [WORD_BITS-1:0] w_rd;
    logic [BW-1:0]        w_base;
    logic [BW:0]          w_rem;
    logic [CW-1:0]        w_clip;
    logic [WORD_BITS-1:0] w_valid;
    logic [WORD_BITS-1:0] w_free;
    logic                 w_hit;
    logic [OW-1:0]        w_first;
    logic [CW-1:0]        w_cnt;
    logic [BW-1:0]        w_gbit;
    logic [IDX_W-1:0]     w_granted;
    logic                 w_upd_we;
    logic                 w_hit_we;
    logic                 w_we_i;
    logic                 w_we_z;
    logic [AW-1:0]        w_wa;
    logic [WORD_BITS-1:0] w_wd;
    logic [WORD_BITS-1:0] w_bit_mask;
    logic [AW-1:0]        w_raddr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fdz <= '0;
            r_zc  <= '0;
            r_ic  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FIRST_ZONE:  r_fdz <= i_cfg_data[FDZ_W-1:0];
                CFG_ZONE_COUNT:  r_zc  <= i_cfg_data[ZCNT_W-1:0];
                CFG_INODE_COUNT: r_ic  <= i_cfg_data[ICNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= i_action;
            r_sel    <= i_map_select;
            r_idx    <= i_item_index;
        end
    end

    // single-bit access decode
    assign w_zone_map = (r_action == ACT_COUNT) || r_sel;
    assign w_is_alloc = (r_action == ACT_ALLOC);
    assign w_is_scan  = w_is_alloc || (r_action == ACT_COUNT);
    assign w_reserved = r_sel && (r_idx < IDX_W'(r_fdz));
    assign w_bit      = r_sel ? (r_idx - IDX_W'(r_fdz)) : r_idx;
    assign w_oor      = !w_reserved && (BW'(w_bit) >= MAP_LIMIT);
    assign w_waddr    = w_bit[OW +: AW];
    assign w_off      = w_bit[OW-1:0];
    assign w_bit_mask = WORD_BITS'(1) << w_off;

    // exclusive upper bit bound of the scan
    assign w_zlim = (r_zc > ZCNT_W'(r_fdz)) ? BW'(r_zc - ZCNT_W'(r_fdz)) : '0;
    assign w_ilim = BW'(r_ic) + BW'(1);
    assign w_lim  = w_zone_map ? w_zlim : w_ilim;

    assign w_rd = w_zone_map ? r_zrd : r_ird;

    // per-word scan evaluation
    assign w_base = BW'({r_pa, {OW{1'b0}}});
    assign w_rem  = {1'b0, r_upper} - {1'b0, w_base};

    always_comb begin
        if (w_rem[BW]) begin
            w_clip = '0;
        end else if (w_rem >= WORD_SPAN) begin
            w_clip = CW'(WORD_BITS);
        end else begin
            w_clip = w_rem[CW-1:0];
        end
    end

    always_comb begin
        for (int j = 0; j < WORD_BITS; j++) begin
            w_valid[j] = (CW'(j) < w_clip);
        end
        // inode zero is never handed out
        if (r_lo_one && (r_pa == '0)) begin
            w_valid[0] = 1'b0;
        end
    end

    assign w_free = ~w_rd & w_valid & {WORD_BITS{r_pv}};

    always_comb begin
        w_hit   = 1'b0;
        w_first = '0;
        for (int j = WORD_BITS - 1; j >= 0; j--) begin
            if (w_free[j]) begin
                w_hit   = 1'b1;
                w_first = OW'(j);
            end
        end
    end

    assign w_cnt     = CW'($countones(w_free));
    assign w_gbit    = w_base + BW'(w_first);
    assign w_granted = w_zone_map ? (w_gbit[IDX_W-1:0] + IDX_W'(r_fdz)) : w_gbit[IDX_W-1:0];

    // memory write and read selection
    assign w_upd_we = i_cmd.upd && ((r_action == ACT_SET) || (r_action == ACT_CLEAR))
                      && !w_reserved && !w_oor;
    assign w_hit_we = i_cmd.scan && w_is_alloc && w_hit;
    assign w_we_i   = i_cmd.clr || ((w_upd_we || w_hit_we) && !w_zone_map);
    assign w_we_z   = i_cmd.clr || ((w_upd_we || w_hit_we) && w_zone_map);
    assign w_raddr  = i_cmd.scan ? r_sa[AW-1:0] : w_waddr;

    always_comb begin
        if (i_cmd.clr) begin
            w_wa = r_clr;
            w_wd = '0;
        end else if (i_cmd.upd) begin
            w_wa = w_waddr;
            w_wd = (r_action == ACT_SET) ? (w_rd | w_bit_mask) : (w_rd & ~w_bit_mask);
        end else begin
            w_wa = r_pa;
            w_wd = w_rd | (WORD_BITS'(1) << w_first);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we_i) begin
            r_imem[w_wa] <= w_wd;
        end
        r_ird <= r_imem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_we_z) begin
            r_zmem[w_wa] <= w_wd;
        end
        r_zrd <= r_zmem[w_raddr];
    end

    // clear sweep and scan address pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr    <= '0;
            r_sa     <= '0;
            r_pv     <= 1'b0;
            r_upper  <= '0;
            r_lo_one <= 1'b0;
        end else begin
            if (i_cmd.clr) begin
                r_clr <= r_clr + AW'(1);
            end
            if (i_cmd.prep) begin
                r_sa     <= '0;
                r_pv     <= 1'b0;
                r_upper  <= (w_lim > MAP_LIMIT) ? MAP_LIMIT : w_lim;
                r_lo_one <= !w_zone_map;
            end else if (i_cmd.scan) begin
                r_pv <= (r_sa < WORD_TOTAL);
                if (r_sa < WORD_TOTAL) begin
                    r_sa <= r_sa + SW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan) begin
            r_pa <= r_sa[AW-1:0];
        end
    end

    // result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_cmd.prep) begin
            r_acc <= '0;
        end else if (i_cmd.scan && !w_is_alloc) begin
            r_acc <= r_acc + IDX_W'(w_cnt);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.prep) begin
            r_res_in_use  <= 1'b0;
            r_res_granted <= '0;
            r_res_status  <= w_is_alloc ? ST_FULL : ST_OK;
        end else if (i_cmd.upd) begin
            case (r_action)
                ACT_QUERY: begin
                    r_res_in_use <= w_reserved || (!w_oor && w_rd[w_off]);
                    r_res_status <= w_oor ? ST_RANGE : ST_OK;
                end
                ACT_SET, ACT_CLEAR: begin
                    r_res_status <= w_oor ? ST_RANGE : ST_OK;
                end
                default: ;
            endcase
        end else if (w_hit_we) begin
            r_res_granted <= w_granted;
            r_res_status  <= ST_OK;
        end
    end

    // output register: next item may run while this word waits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.post) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.post) begin
            r_out_in_use  <= r_res_in_use;
            r_out_granted <= r_res_granted;
            r_out_free    <= r_acc;
            r_out_status  <= r_res_status;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_in_use        = r_out_in_use;
    assign o_granted_index = r_out_granted;
    assign o_free_total    = r_out_free;
    assign o_status        = r_out_status;

    assign o_stat.clr_last = (r_clr == LAST_WORD);
    assign o_stat.is_scan  = w_is_scan;
    assign o_stat.is_alloc = w_is_alloc;
    assign o_stat.hit      = w_hit;
    assign o_stat.last     = r_pv && (r_pa == LAST_WORD);
    assign o_stat.out_busy = r_out_valid && !i_out_ready;

    `FBA_ASSERT(a_post_free, i_clk, i_rst_n, i_cmd.post |-> (!r_out_valid || i_out_ready), "result posted over a waiting word")
    `FBA_ASSERT_NEXT(a_hit_grants, i_clk, i_rst_n, w_hit_we, r_res_status == ST_OK, "allocation hit not reported as ok")
    `FBA_ASSERT(a_count_bound, i_clk, i_rst_n, BW'(r_acc) <= r_upper, "free count above scan bound")

endmodule

// File: bench/testbench.sv
// Self-checking bench for the inode and data zone bitmap allocator.
`timescale 1ns / 100ps

module testbench;
    import fba_pkg::*;

    localparam int MAP_SIZE    = 32768;
    localparam int CYCLE_LIMIT = 3_000_000;
    localparam logic INODE_MAP = 1'b0;
    localparam logic ZONE_MAP  = 1'b1;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic             sel;
        logic [IDX_W-1:0] target;
    } t_req_word;

    typedef struct packed {
        logic              in_use;
        logic [IDX_W-1:0]  granted;
        logic [IDX_W-1:0]  free_total;
        logic [STAT_W-1:0] status;
    } t_alloc_reply;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    fba_req_if req_if ();
    fba_rsp_if rsp_if ();

    fs_bitmap_allocator u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_if),
        .o_rsp      (rsp_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Shadow of the volume: bitmaps and registers.
    bit inode_used [MAP_SIZE];
    bit zone_used  [MAP_SIZE];
    int first_zone;
    int zone_total;
    int inode_limit;

    t_req_word    send_q[$];
    t_alloc_reply awaited[$];
    bit           req_fired;
    int           send_idle_pct;
    int           rsp_stall_pct;
    int           error_count;
    int           cycle_count;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string msg);
        error_count++;
        $display("ERROR @%0t: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [IDX_W-1:0] got,
                               input logic [IDX_W-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
    endtask

    function automatic bit zone_taken(int z);
        if (z < first_zone) return 1'b1;
        if (z - first_zone >= MAP_SIZE) return 1'b1;
        return zone_used[z - first_zone];
    endfunction

    function automatic t_alloc_reply bitmap_outcome(t_req_word w);
        t_alloc_reply rep;
        int           bit_no;
        int           z;
        bit           found;
        rep   = '0;
        found = 1'b0;
        if (w.action == ACT_QUERY || w.action == ACT_SET || w.action == ACT_CLEAR) begin
            bit_no = int'(w.target) - ((w.sel == ZONE_MAP) ? first_zone : 0);
            if (w.sel == ZONE_MAP && int'(w.target) < first_zone) begin
                // reserved zone: reads used, never changes
                if (w.action == ACT_QUERY) rep.in_use = 1'b1;
            end else if (bit_no >= MAP_SIZE) begin
                rep.status = ST_RANGE;
            end else if (w.action == ACT_QUERY) begin
                rep.in_use = (w.sel == ZONE_MAP) ? zone_used[bit_no] : inode_used[bit_no];
            end else if (w.sel == ZONE_MAP) begin
                zone_used[bit_no] = (w.action == ACT_SET);
            end else begin
                inode_used[bit_no] = (w.action == ACT_SET);
            end
        end else if (w.action == ACT_ALLOC) begin
            rep.status = ST_FULL;
            if (w.sel == ZONE_MAP) begin
                for (z = 0; z < zone_total && !found; z++) begin
                    if (!zone_taken(z)) begin
                        zone_used[z - first_zone] = 1'b1;
                        rep.granted = IDX_W'(z);
                        rep.status  = ST_OK;
                        found       = 1'b1;
                    end
                end
            end else begin
                for (z = 1; z <= inode_limit && z < MAP_SIZE && !found; z++) begin
                    if (!inode_used[z]) begin
                        inode_used[z] = 1'b1;
                        rep.granted   = IDX_W'(z);
                        rep.status    = ST_OK;
                        found         = 1'b1;
                    end
                end
            end
        end else if (w.action == ACT_COUNT) begin
            for (z = 0; z < zone_total; z++)
                if (!zone_taken(z)) rep.free_total = rep.free_total + 1'b1;
        end
        return rep;
    endfunction

    // Request driver: hold the word until taken, then advance or idle.
    always @(negedge i_clk) begin : drive_requests
        t_req_word nxt;
        if (i_rst_n && (!req_if.valid || req_fired)) begin
            if (send_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                nxt = send_q.pop_front();
                req_if.action     <= nxt.action;
                req_if.map_select <= nxt.sel;
                req_if.item_index <= nxt.target;
                req_if.valid      <= 1'b1;
            end else begin
                req_if.valid <= 1'b0;
            end
        end
        rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);
    end

    // Monitor: check result words first, then predict newly taken requests.
    always @(posedge i_clk) begin : watch_channels
        t_alloc_reply want;
        cycle_count++;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (awaited.size() == 0) begin
                report_mismatch("result word with nothing outstanding");
            end else begin
                want = awaited.pop_front();
                check_field("in_use", IDX_W'(rsp_if.in_use), IDX_W'(want.in_use));
                check_field("granted_index", rsp_if.granted_index, want.granted);
                check_field("free_total", rsp_if.free_total, want.free_total);
                check_field("status", IDX_W'(rsp_if.status), IDX_W'(want.status));
            end
        end
        req_fired = i_rst_n && req_if.valid && req_if.ready;
        if (req_fired)
            awaited.insert(awaited.size(),
                           bitmap_outcome(t_req_word'({req_if.action, req_if.map_select,
                                                       req_if.item_index})));
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk);
        $display("simulation failed");
        $finish;
    end

    task automatic enqueue(input int act, input logic sel, input int target);
        t_req_word w;
        w.action = ACT_W'(act);
        w.sel    = sel;
        w.target = IDX_W'(target);
        send_q.insert(send_q.size(), w);
    endtask

    task automatic write_reg(input t_cfg_reg which, input int value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= which;
        i_cfg_data <= value[CFG_W-1:0];
        case (which)
            CFG_FIRST_ZONE:  first_zone  = value & ((1 << FDZ_W) - 1);
            CFG_ZONE_COUNT:  zone_total  = value & ((1 << ZCNT_W) - 1);
            CFG_INODE_COUNT: inode_limit = value & ((1 << ICNT_W) - 1);
            default: ;
        endcase
    endtask

    task automatic program_volume(input int fdz, input int zc, input int ic);
        write_reg(CFG_FIRST_ZONE, fdz);
        write_reg(CFG_ZONE_COUNT, zc);
        write_reg(CFG_INODE_COUNT, ic);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        while (send_q.size() != 0 || req_if.valid || awaited.size() != 0)
            @(posedge i_clk);
    endtask

    // Mostly in-range numbers, some map edges, some anything.
    function automatic int pick_index(logic sel);
        int r;
        r = $urandom_range(99);
        if (r < 10) return $urandom_range((1 << IDX_W) - 1);
        if (r < 20) begin
            case ($urandom_range(3))
                0: return sel ? first_zone + MAP_SIZE - 1 : MAP_SIZE - 1;
                1: return sel ? first_zone + MAP_SIZE : MAP_SIZE;
                2: return sel ? first_zone : 0;
                default: return sel ? first_zone - 1 : inode_limit;
            endcase
        end
        return sel ? $urandom_range(zone_total + 3) : $urandom_range(inode_limit + 3);
    endfunction

    task automatic queue_random_items(input int n);
        int   made;
        int   r;
        logic sel;
        int   idx;
        made = 0;
        while (made < n) begin
            r   = $urandom_range(99);
            sel = 1'($urandom_range(1));
            idx = pick_index(sel);
            if (r < 30) begin
                // touch a bit, then read it back
                enqueue($urandom_range(1) ? ACT_SET : ACT_CLEAR, sel, idx);
                enqueue(ACT_QUERY, sel, idx);
                made += 2;
            end else if (r < 45) begin
                // free one, reclaim the first free, look at the freed one
                enqueue(ACT_CLEAR, sel, idx);
                enqueue(ACT_ALLOC, sel, $urandom_range((1 << IDX_W) - 1));
                enqueue(ACT_QUERY, sel, idx);
                made += 3;
            end else if (r < 70) begin
                enqueue($urandom_range(int'(ACT_COUNT)), sel, idx);
                made++;
            end else if (r < 85) begin
                enqueue(ACT_ALLOC, sel, $urandom_range((1 << IDX_W) - 1));
                made++;
            end else if (r < 91) begin
                enqueue(ACT_COUNT, sel, $urandom_range((1 << IDX_W) - 1));
                made++;
            end else begin
                enqueue($urandom_range(int'(ACT_COUNT) + 1, (1 << ACT_W) - 1), sel, idx);
                made++;
            end
        end
    endtask

    task automatic run_phase(input int fdz, input int zc, input int ic, input int idle_pct,
                             input int stall_pct, input int n, input bit hold_mid);
        wait_drained();
        repeat (8) @(posedge i_clk);
        program_volume(fdz, zc, ic);
        @(posedge i_clk);
        send_idle_pct = idle_pct;
        rsp_stall_pct = stall_pct;
        if (hold_mid) begin
            // pause the sender until every outstanding result is back
            queue_random_items(n / 2);
            wait_drained();
            queue_random_items(n - n / 2);
        end else begin
            queue_random_items(n);
        end
    endtask

    initial begin : stimulus
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_idx         = '0;
        i_cfg_data        = '0;
        req_if.valid      = 1'b0;
        req_if.action     = '0;
        req_if.map_select = 1'b0;
        req_if.item_index = '0;
        rsp_if.ready      = 1'b1;
        req_fired         = 1'b0;
        send_idle_pct     = 0;
        rsp_stall_pct     = 0;
        error_count       = 0;
        cycle_count       = 0;
        first_zone        = 0;
        zone_total        = 0;
        inode_limit       = 0;

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        // let the clearing pass finish
        repeat (2) @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);

        program_volume(4, 40, 6);
        enqueue(ACT_QUERY, INODE_MAP, 0);
        enqueue(ACT_SET, INODE_MAP, 0);
        enqueue(ACT_QUERY, INODE_MAP, 0);
        enqueue(ACT_CLEAR, INODE_MAP, 0);
        enqueue(ACT_SET, INODE_MAP, MAP_SIZE - 1);
        enqueue(ACT_QUERY, INODE_MAP, MAP_SIZE - 1);
        enqueue(ACT_QUERY, INODE_MAP, MAP_SIZE);
        enqueue(ACT_SET, INODE_MAP, 16'hFFFF);
        enqueue(ACT_QUERY, ZONE_MAP, 3);
        enqueue(ACT_SET, ZONE_MAP, 3);
        enqueue(ACT_CLEAR, ZONE_MAP, 3);
        enqueue(ACT_QUERY, ZONE_MAP, 4);
        enqueue(ACT_SET, ZONE_MAP, 4 + MAP_SIZE - 1);
        enqueue(ACT_QUERY, ZONE_MAP, 4 + MAP_SIZE - 1);
        enqueue(ACT_CLEAR, ZONE_MAP, 4 + MAP_SIZE);
        enqueue(ACT_ALLOC, ZONE_MAP, 0);
        enqueue(ACT_COUNT, INODE_MAP, 16'hFFFF);
        enqueue(ACT_CLEAR, ZONE_MAP, 4);
        enqueue(ACT_ALLOC, ZONE_MAP, 16'hFFFF);
        enqueue(int'(ACT_COUNT) + 1, ZONE_MAP, 16'hFFFF);
        enqueue((1 << ACT_W) - 1, INODE_MAP, 0);
        // run the inode map dry
        repeat (7) enqueue(ACT_ALLOC, INODE_MAP, 0);
        enqueue(ACT_QUERY, INODE_MAP, 6);

        run_phase(0, 0, 0, 54, 0, 40, 1'b0);
        run_phase(10, 48, 12, 0, 54, 120, 1'b0);
        run_phase(16'hFFFF, 65535, 16'hFFFF, 10, 10, 60, 1'b0);
        run_phase(100, 200, 40, 0, 0, 120, 1'b1);
        run_phase(3, 20, 3, 54, 0, 110, 1'b0);
        run_phase(0, 65535, 100, 0, 54, 110, 1'b0);

        wait_drained();
        repeat (1100) @(posedge i_clk);
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+design
design/fba_pkg.sv
design/fba_ifs.sv
design/fba_ctrl.sv
design/fba_datapath.sv
design/fs_bitmap_allocator.sv
bench/testbench.sv
